@@ sv/pooled_message_fifo_macros.svh @@
// Assertion macros for the pooled message FIFO.
// No dependencies; the asserting file supplies clk_i and rst_ni.
`ifndef POOLED_MESSAGE_FIFO_MACROS_SVH
`define POOLED_MESSAGE_FIFO_MACROS_SVH

`ifndef SYNTHESIS
// Expression must hold at every edge out of reset.
`define PMF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pmf: invariant violated");
// Consequent must hold in the same cycle as the antecedent.
`define PMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmf: implication violated");
`else
`define PMF_ASSERT_ALWAYS(lbl, expr)
`define PMF_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

@@ sv/pmf_pkg.sv @@
// Shared types and constants of the pooled message FIFO.
// No dependencies; used by the channel interfaces and the top level.
package pmf_pkg;

  localparam int POOL_ENTRIES_DEF = 16;
  localparam int ITEM_BYTES_DEF   = 32;

  localparam int DATA_W   = 8;
  localparam int LEN_W    = 6;  // msg_length and stored length
  localparam int FILL_W   = 6;  // byte index of the message being pushed
  localparam int CNT_OUT_W = 5; // count and free_count fields
  localparam int LIMIT_W  = 7;  // compares against ITEM_BYTES up to 64

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 1'b0;
  localparam logic [LEN_W-1:0]     MAX_LEN_RST = 6'd32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ERR_LONG = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

endpackage

@@ sv/pmf_in_if.sv @@
// Input channel of the pooled message FIFO: one push byte or one pop request per beat.
// Depends on pmf_pkg.
interface pmf_in_if;
  logic                         valid;
  logic                         ready;
  pmf_pkg::op_e                 opcode;
  logic [pmf_pkg::DATA_W-1:0]   data_byte;
  logic                         last_byte;

  modport source (output valid, opcode, data_byte, last_byte, input ready);
  modport sink   (input valid, opcode, data_byte, last_byte, output ready);
endinterface

@@ sv/pmf_out_if.sv @@
// Result channel of the pooled message FIFO: one status or one popped byte per beat.
// Depends on pmf_pkg.
interface pmf_out_if;
  logic                            valid;
  logic                            ready;
  pmf_pkg::status_e                status;
  logic                            from_pop;
  logic [pmf_pkg::DATA_W-1:0]      byte_out;
  logic [pmf_pkg::LEN_W-1:0]       msg_length;
  logic                            last;
  logic [pmf_pkg::CNT_OUT_W-1:0]   count;
  logic [pmf_pkg::CNT_OUT_W-1:0]   free_count;

  modport source (output valid, status, from_pop, byte_out, msg_length, last, count,
                  free_count, input ready);
  modport sink   (input valid, status, from_pop, byte_out, msg_length, last, count,
                  free_count, output ready);
endinterface

@@ sv/pooled_message_fifo.sv @@
// Pooled message FIFO: variable-length byte messages queued in a fixed pool of
// POOL_ENTRIES nodes of ITEM_BYTES bytes each; free nodes form a LIFO free list.
// Depends on pmf_pkg, pmf_in_if, pmf_out_if and pooled_message_fifo_macros.svh.
//
// Usage and timing: a push byte that is not the last of its message gives no
// result beat. A rejected last push byte (too long, or no free node) is answered
// from ST_IDLE; a committed one goes on through ST_PUSH_LINK, because the
// free-list link of the filled node comes out of the link memory in the cycle
// after it is addressed. An empty pop is answered from ST_IDLE; a stored message
// is popped through ST_POP_LINK (link and length reads), then ST_POP_OUT, one
// byte beat per cycle from the payload memory while the result side takes them.
// The block holds one item at a time; a push byte that makes no result is still
// taken while an earlier result waits in the output register. max_len (APB
// offset 0, reset 32) caps the message length together with ITEM_BYTES; the
// user must see that it is written only while idle; the block does not enforce
// it. All state memories start without a clearing pass: the link memory carries
// a valid bit per node and reads its reset chain until written.
module pooled_message_fifo #(
  parameter int POOL_ENTRIES = pmf_pkg::POOL_ENTRIES_DEF,
  parameter int ITEM_BYTES   = pmf_pkg::ITEM_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pmf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pmf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  // channels
  pmf_in_if.sink                            in_i,
  pmf_out_if.source                         out_o
);

  `include "pooled_message_fifo_macros.svh"

  // ---------------------------------------------------------------------------
  // Sizes
  // ---------------------------------------------------------------------------
  localparam int NODE_W    = $clog2(POOL_ENTRIES + 1);          // holds "no node"
  localparam int LNK_AW    = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int PAY_DEPTH = POOL_ENTRIES * ITEM_BYTES;
  localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;
  localparam int CNT_W     = $clog2(ITEM_BYTES + 1);            // byte index / length
  localparam int CNT_XW    = (NODE_W > pmf_pkg::CNT_OUT_W) ? NODE_W : pmf_pkg::CNT_OUT_W;
  localparam int LIM_W     = pmf_pkg::LIMIT_W;

  localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(POOL_ENTRIES);
  localparam logic [NODE_W-1:0] NODE_TOP  = NODE_W'(POOL_ENTRIES - 1);
  localparam logic [LIM_W-1:0]  ITEM_LIM  = LIM_W'(ITEM_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,  // take an input item
    ST_PUSH_LINK = 4'b0010,  // commit: free-list link read is back
    ST_POP_LINK  = 4'b0100,  // pop: link and length reads are back
    ST_POP_OUT   = 4'b1000   // pop: stream payload bytes
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                       state_q, state_d;
  logic [pmf_pkg::LEN_W-1:0]    max_len_q;
  logic [pmf_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic                         reject_q, reject_d;
  logic [NODE_W-1:0]            free_head_q, free_head_d;
  logic [NODE_W-1:0]            act_head_q, act_head_d;
  logic [NODE_W-1:0]            act_tail_q, act_tail_d;
  logic [NODE_W-1:0]            cnt_q, cnt_d;
  logic [NODE_W-1:0]            node_q, node_d;       // node being committed or popped
  logic [CNT_W-1:0]             idx_q, idx_d;         // pop byte index
  logic [CNT_W-1:0]             len_q, len_d;         // pop beat count
  logic [pmf_pkg::LEN_W-1:0]    msg_len_q, msg_len_d; // stored length, reported

  // output register
  logic                          out_valid_q;
  pmf_pkg::status_e              out_status_q, out_status_d;
  logic                          out_from_pop_q, out_from_pop_d;
  logic [pmf_pkg::DATA_W-1:0]    out_byte_q, out_byte_d;
  logic [pmf_pkg::LEN_W-1:0]     out_len_q, out_len_d;
  logic                          out_last_q;
  logic [pmf_pkg::CNT_OUT_W-1:0] out_cnt_q, out_free_q;
  logic                          out_load;
  logic                          out_free;
  logic [CNT_XW-1:0]             cnt_ext, free_ext;

  // memories
  logic [pmf_pkg::DATA_W-1:0]    pay_mem [PAY_DEPTH];
  logic [pmf_pkg::DATA_W-1:0]    pay_rd_q;
  logic                          pay_we, pay_re;
  logic [PAY_AW-1:0]             pay_waddr, pay_raddr;

  logic [NODE_W-1:0]             lnk_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0]       lnk_vld_q;
  logic [NODE_W-1:0]             lnk_rd_q;
  logic                          lnk_we, lnk_re;
  logic [LNK_AW-1:0]             lnk_waddr, lnk_raddr;
  logic [NODE_W-1:0]             lnk_wdata;

  logic [pmf_pkg::LEN_W-1:0]     len_mem [POOL_ENTRIES];
  logic [pmf_pkg::LEN_W-1:0]     len_rd_q;
  logic                          len_we, len_re;
  logic [LNK_AW-1:0]             len_waddr, len_raddr;
  logic [pmf_pkg::LEN_W-1:0]     len_wdata;

  // push datapath
  logic [LIM_W-1:0]              limit;
  logic                          push_store, reject_new, free_valid, fill_fits;
  logic [pmf_pkg::FILL_W-1:0]    fill_new;
  logic [LIM_W-1:0]              len_clamp;
  logic [CNT_W-1:0]              idx_nxt;
  logic                          in_ready;
  logic                          cfg_wr;

  // Base of a node's payload area.
  function automatic logic [PAY_AW-1:0] pay_base(logic [NODE_W-1:0] node);
    pay_base = PAY_AW'(PAY_AW'(node[LNK_AW-1:0]) * PAY_AW'(ITEM_BYTES));
  endfunction

  // Reset image of the link memory: descending free chain, node 0 ends it.
  function automatic logic [NODE_W-1:0] link_reset_val(logic [LNK_AW-1:0] a);
    link_reset_val = (a == '0) ? NODE_NONE : NODE_W'(NODE_W'(a) - 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[pmf_pkg::CFG_ADDR_W-1:2] == pmf_pkg::REG_MAX_LEN)
                ? pmf_pkg::CFG_DATA_W'(max_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= pmf_pkg::MAX_LEN_RST;
    end else if (cfg_wr && paddr[pmf_pkg::CFG_ADDR_W-1:2] == pmf_pkg::REG_MAX_LEN) begin
      max_len_q <= pwdata[pmf_pkg::LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Push byte bookkeeping: limit is min(max_len, ITEM_BYTES); the first byte
  // past it latches a rejection and later bytes of the message are dropped.
  // ---------------------------------------------------------------------------
  assign limit      = (LIM_W'(max_len_q) < ITEM_LIM) ? LIM_W'(max_len_q) : ITEM_LIM;
  assign push_store = !reject_q && (LIM_W'(fill_q) < limit);
  assign reject_new = reject_q || !push_store;
  assign fill_new   = push_store ? fill_q + 1'b1 : fill_q;
  assign free_valid = (free_head_q != NODE_NONE);
  assign fill_fits  = (LIM_W'(fill_q) < ITEM_LIM);

  // stored length clamped to 1..ITEM_BYTES beats
  assign len_clamp = (LIM_W'(len_rd_q) > ITEM_LIM) ? ITEM_LIM :
                     (len_rd_q == '0) ? LIM_W'(1) : LIM_W'(len_rd_q);
  assign idx_nxt   = idx_q + 1'b1;

  assign out_free  = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    reject_d    = reject_q;
    free_head_d = free_head_q;
    act_head_d  = act_head_q;
    act_tail_d  = act_tail_q;
    cnt_d       = cnt_q;
    node_d      = node_q;
    idx_d       = idx_q;
    len_d       = len_q;
    msg_len_d   = msg_len_q;

    pay_we    = 1'b0;
    pay_waddr = PAY_AW'(pay_base(free_head_q) + PAY_AW'(fill_q));
    pay_re    = 1'b0;
    pay_raddr = pay_base(act_head_q);
    lnk_we    = 1'b0;
    lnk_waddr = node_q[LNK_AW-1:0];
    lnk_wdata = NODE_NONE;
    lnk_re    = 1'b0;
    lnk_raddr = free_head_q[LNK_AW-1:0];
    len_we    = 1'b0;
    len_waddr = free_head_q[LNK_AW-1:0];
    len_wdata = fill_new;
    len_re    = 1'b0;
    len_raddr = act_head_q[LNK_AW-1:0];

    out_load       = 1'b0;
    out_status_d   = pmf_pkg::STAT_OK;
    out_from_pop_d = 1'b0;
    out_byte_d     = '0;
    out_len_d      = '0;
    in_ready       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // a mid-message push byte makes no beat, so it never waits on the output
        in_ready = out_free || (in_i.opcode == pmf_pkg::OP_PUSH && !in_i.last_byte);
        if (in_i.valid && in_ready) begin
          if (in_i.opcode == pmf_pkg::OP_PUSH) begin
            fill_d   = fill_new;
            reject_d = reject_new;
            pay_we   = push_store && free_valid && fill_fits;
            if (in_i.last_byte) begin
              fill_d   = '0;
              reject_d = 1'b0;
              if (reject_new) begin
                out_load     = 1'b1;
                out_status_d = pmf_pkg::STAT_ERR_LONG;
              end else if (!free_valid) begin
                out_load     = 1'b1;
                out_status_d = pmf_pkg::STAT_FULL;
              end else begin
                // take the free head: store its length, fetch its link,
                // hook it behind the current tail
                node_d = free_head_q;
                len_we = 1'b1;
                lnk_re = 1'b1;
                if (act_tail_q != NODE_NONE) begin
                  lnk_we    = 1'b1;
                  lnk_waddr = act_tail_q[LNK_AW-1:0];
                  lnk_wdata = free_head_q;
                end
                state_d = ST_PUSH_LINK;
              end
            end
          end else begin
            fill_d   = '0;
            reject_d = 1'b0;
            if (act_head_q == NODE_NONE) begin
              out_load       = 1'b1;
              out_status_d   = pmf_pkg::STAT_EMPTY;
              out_from_pop_d = 1'b1;
            end else begin
              node_d    = act_head_q;
              lnk_re    = 1'b1;
              lnk_raddr = act_head_q[LNK_AW-1:0];
              len_re    = 1'b1;
              pay_re    = 1'b1;
              idx_d     = '0;
              state_d   = ST_POP_LINK;
            end
          end
        end
      end

      ST_PUSH_LINK: begin
        free_head_d = lnk_rd_q;
        lnk_we      = 1'b1;               // new tail ends the queue
        if (act_head_q == NODE_NONE) begin
          act_head_d = node_q;
        end
        act_tail_d = node_q;
        cnt_d      = cnt_q + 1'b1;
        out_load   = 1'b1;                // slot was reserved at accept
        state_d    = ST_IDLE;
      end

      ST_POP_LINK: begin
        act_head_d = lnk_rd_q;
        if (lnk_rd_q == NODE_NONE) begin
          act_tail_d = NODE_NONE;
        end
        lnk_we      = 1'b1;               // node goes back on the free list
        lnk_wdata   = free_head_q;
        free_head_d = node_q;
        cnt_d       = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
        msg_len_d   = len_rd_q;
        len_d       = CNT_W'(len_clamp);
        state_d     = ST_POP_OUT;
      end

      ST_POP_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_from_pop_d = 1'b1;
          out_byte_d     = pay_rd_q;
          out_len_d      = msg_len_q;
          if (idx_nxt == len_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_nxt;
            pay_re    = 1'b1;
            pay_raddr = PAY_AW'(pay_base(node_q) + PAY_AW'(idx_nxt));
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready = in_ready;

  // counts carried by every beat reflect the state after this step
  assign cnt_ext  = CNT_XW'(cnt_d);
  assign free_ext = CNT_XW'(NODE_W'(NODE_W'(POOL_ENTRIES) - cnt_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      reject_q    <= 1'b0;
      free_head_q <= NODE_TOP;
      act_head_q  <= NODE_NONE;
      act_tail_q  <= NODE_NONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      reject_q    <= reject_d;
      free_head_q <= free_head_d;
      act_head_q  <= act_head_d;
      act_tail_q  <= act_tail_d;
      cnt_q       <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    idx_q     <= idx_d;
    len_q     <= len_d;
    msg_len_q <= msg_len_d;
    if (out_load) begin
      out_status_q   <= out_status_d;
      out_from_pop_q <= out_from_pop_d;
      out_byte_q     <= out_byte_d;
      out_len_q      <= out_len_d;
      // push and empty results are single beats; pop marks its final byte
      out_last_q     <= !out_from_pop_d || out_status_d == pmf_pkg::STAT_EMPTY
                        || idx_nxt == len_q;
      out_cnt_q      <= cnt_ext[pmf_pkg::CNT_OUT_W-1:0];
      out_free_q     <= free_ext[pmf_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.from_pop   = out_from_pop_q;
  assign out_o.byte_out   = out_byte_q;
  assign out_o.msg_length = out_len_q;
  assign out_o.last       = out_last_q;
  assign out_o.count      = out_cnt_q;
  assign out_o.free_count = out_free_q;

  // ---------------------------------------------------------------------------
  // Memories: one write and one registered read per cycle each. Reads and
  // writes never hit the same entry in one cycle, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= in_i.data_byte;
    end
    if (pay_re) begin
      pay_rd_q <= pay_mem[pay_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    if (lnk_re) begin
      lnk_rd_q <= lnk_vld_q[lnk_raddr] ? lnk_mem[lnk_raddr] : link_reset_val(lnk_raddr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lnk_vld_q <= '0;
    end else if (lnk_we) begin
      lnk_vld_q[lnk_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PMF_ASSERT_ALWAYS(a_head_tracks_count, (cnt_q == '0) == (act_head_q == NODE_NONE))
  `PMF_ASSERT_ALWAYS(a_free_tracks_count, (free_head_q == NODE_NONE) == (cnt_q == NODE_NONE))
  `PMF_ASSERT_IMPL(a_tail_tracks_head, act_head_q == NODE_NONE, act_tail_q == NODE_NONE)
  `PMF_ASSERT_IMPL(a_pop_idx_in_range, state_q == ST_POP_OUT, idx_q < len_q)

endmodule

@@ sim/pmf_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the pooled message FIFO: tracks the node pool from observed beats
// and register writes, predicts every result beat and compares it field by field.
// Depends on pmf_pkg, pmf_in_if and pmf_out_if.
module pmf_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [pmf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pmf_pkg::CFG_DATA_W-1:0] pwdata,
  pmf_in_if                              in_i,
  pmf_out_if                             out_i,
  output int                             fail_count_o,
  output int                             awaited_o
);

  localparam int POOL       = pmf_pkg::POOL_ENTRIES_DEF;
  localparam int NODE_BYTES = pmf_pkg::ITEM_BYTES_DEF;
  localparam int NODE_W     = $clog2(POOL + 1);
  localparam int DW         = pmf_pkg::DATA_W;
  localparam int LW         = pmf_pkg::LEN_W;
  localparam int CW         = pmf_pkg::CNT_OUT_W;
  localparam logic [NODE_W-1:0] NO_NODE = NODE_W'(POOL);
  localparam logic [pmf_pkg::CFG_ADDR_W-1:0] MAX_LEN_ADDR =
    pmf_pkg::CFG_ADDR_W'(4 * pmf_pkg::REG_MAX_LEN);

  typedef struct packed {
    pmf_pkg::status_e status;
    logic             from_pop;
    logic [DW-1:0]    byte_out;
    logic [LW-1:0]    msg_length;
    logic             last;
    logic [CW-1:0]    count;
    logic [CW-1:0]    free_count;
  } result_t;

  logic [DW-1:0]                  node_bytes [POOL][NODE_BYTES];
  logic [LW-1:0]                  node_len   [POOL];
  logic [NODE_W-1:0]              node_next  [POOL];
  logic [NODE_W-1:0]              free_top;
  logic [NODE_W-1:0]              queue_head;
  logic [NODE_W-1:0]              queue_tail;
  logic [CW-1:0]                  queued;
  logic [pmf_pkg::FILL_W-1:0]     fill_pos;
  logic                           rejecting;
  logic [LW-1:0]                  max_len_reg;
  result_t                        awaited_beats[$];
  int                             misses;

  function automatic void clear_pool();
    for (int i = 0; i < POOL; i++) begin
      node_next[i] = (i == 0) ? NO_NODE : NODE_W'(i - 1);
      node_len[i]  = '0;
    end
    free_top    = NODE_W'(POOL - 1);
    queue_head  = NO_NODE;
    queue_tail  = NO_NODE;
    queued      = '0;
    fill_pos    = '0;
    rejecting   = 1'b0;
    max_len_reg = pmf_pkg::MAX_LEN_RST;
    awaited_beats.delete();
  endfunction

  function automatic void expect_beat(pmf_pkg::status_e st, logic pop, logic [DW-1:0] b,
                                      logic [LW-1:0] len, logic lst);
    result_t r;
    r.status     = st;
    r.from_pop   = pop;
    r.byte_out   = b;
    r.msg_length = len;
    r.last       = lst;
    r.count      = queued;
    r.free_count = CW'(POOL - int'(queued));
    awaited_beats.push_back(r);
  endfunction

  // One push byte: store into the node on top of the free list while in range.
  function automatic void push_byte(logic [DW-1:0] b, logic lst);
    int                lim;
    pmf_pkg::status_e  st;
    logic [NODE_W-1:0] node;
    lim = (int'(max_len_reg) < NODE_BYTES) ? int'(max_len_reg) : NODE_BYTES;
    if (!rejecting) begin
      if (int'(fill_pos) >= lim) rejecting = 1'b1;
      else begin
        if (free_top < NO_NODE) node_bytes[free_top][fill_pos] = b;
        fill_pos = fill_pos + 1'b1;
      end
    end
    if (!lst) return;
    if (rejecting) st = pmf_pkg::STAT_ERR_LONG;  // too long wins over full
    else if (free_top >= NO_NODE) st = pmf_pkg::STAT_FULL;
    else begin
      node            = free_top;
      free_top        = node_next[node];
      node_len[node]  = fill_pos;
      node_next[node] = NO_NODE;
      if (queue_head >= NO_NODE) queue_head = node;
      else node_next[queue_tail] = node;
      queue_tail = node;
      queued     = queued + 1'b1;
      st         = pmf_pkg::STAT_OK;
    end
    fill_pos  = '0;
    rejecting = 1'b0;
    expect_beat(st, 1'b0, '0, '0, 1'b1);
  endfunction

  // Pop: abandons any partial push, then streams the oldest message out.
  function automatic void pop_message();
    logic [NODE_W-1:0] node;
    int len;
    fill_pos  = '0;
    rejecting = 1'b0;
    if (queue_head >= NO_NODE) begin
      expect_beat(pmf_pkg::STAT_EMPTY, 1'b1, '0, '0, 1'b1);
      return;
    end
    node       = queue_head;
    queue_head = node_next[node];
    if (queue_head >= NO_NODE) queue_tail = NO_NODE;
    len = int'(node_len[node]);
    if (len > NODE_BYTES) len = NODE_BYTES;
    if (len == 0) len = 1;
    node_next[node] = free_top;
    free_top        = node;
    if (queued > 0) queued = queued - 1'b1;
    for (int i = 0; i < len; i++)
      expect_beat(pmf_pkg::STAT_OK, 1'b1, node_bytes[node][i], node_len[node], i == len - 1);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      misses++;
    end
  endfunction

  function automatic void check_beat();
    result_t want;
    if (awaited_beats.size() == 0) begin
      $error("result beat with nothing expected: status %0d from_pop %0b byte 0x%0h",
             out_i.status, out_i.from_pop, out_i.byte_out);
      misses++;
      return;
    end
    want = awaited_beats.pop_front();
    check_field("status", want.status, out_i.status);
    check_field("from_pop", want.from_pop, out_i.from_pop);
    check_field("byte_out", want.byte_out, out_i.byte_out);
    check_field("msg_length", want.msg_length, out_i.msg_length);
    check_field("last", want.last, out_i.last);
    check_field("count", want.count, out_i.count);
    check_field("free_count", want.free_count, out_i.free_count);
  endfunction

  // Inputs first, so a same-cycle result could still find its expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_pool();
      misses = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR)
        max_len_reg = pwdata[LW-1:0];
      if (in_i.valid && in_i.ready) begin
        if (in_i.opcode == pmf_pkg::OP_POP) pop_message();
        else push_byte(in_i.data_byte, in_i.last_byte);
      end
      if (out_i.valid && out_i.ready) check_beat();
    end
    fail_count_o <= misses;
    awaited_o    <= awaited_beats.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the pooled message FIFO testbench: clock, reset, stimulus phases and verdict.
// Depends on pmf_pkg, the channel interfaces, pooled_message_fifo and pmf_result_checker.
module tb_top;

  localparam int DRAIN_CYCLES = 8;    // margin for a committed push to pass through ST_PUSH_LINK
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off to back up the input
  localparam int AW           = pmf_pkg::CFG_ADDR_W;
  localparam int DW           = pmf_pkg::CFG_DATA_W;
  localparam int BW           = pmf_pkg::DATA_W;

  localparam logic [AW-1:0] MAX_LEN_ADDR = AW'(4 * pmf_pkg::REG_MAX_LEN);

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  pmf_in_if  in_ch ();
  pmf_out_if out_ch ();

  int   fail_count;
  int   awaited;
  int   beats_sent;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   cur_max_len;   // mirror of max_len, only used to pick message lengths
  logic hold_off;

  always #4 clk_i = ~clk_i;

  pooled_message_fifo dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  pmf_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .awaited_o    (awaited)
  );

  // Result side: random stalls per phase, forced low during a hold-off.
  always @(posedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // Offer one beat, with random idle cycles in front, and wait for its handshake.
  // valid only drops when an idle cycle is inserted, so it never toggles in one step.
  task automatic send_beat(pmf_pkg::op_e op, logic [BW-1:0] b, logic lb);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lb;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Stop offering, wait until every expected beat came back, then let the
  // block finish any push that makes no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // New phase: write max_len while idle (setup + access), then new idle rates.
  task automatic start_phase(logic [pmf_pkg::LEN_W-1:0] max_len, int idle_pct,
                             int stall_pct);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= DW'(max_len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max_len   = max_len;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
  endtask

  // Random traffic: mostly whole messages and pops, some cut-off messages
  // (a pop or the next message lands mid-push) and some raw noise beats.
  task automatic random_traffic(int n_beats, int push_pct);
    int stop_at, lim, len, pick, shape;
    bit cut;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_beat(pmf_pkg::op_e'($urandom_range(1)), BW'($urandom), 1'($urandom));
      end else if (pick < 5 + push_pct) begin
        lim   = (cur_max_len < pmf_pkg::ITEM_BYTES_DEF) ? cur_max_len
                                                         : pmf_pkg::ITEM_BYTES_DEF;
        shape = $urandom_range(9);
        if (lim == 0) len = $urandom_range(3, 1);
        else if (shape == 0) len = lim + $urandom_range(1);      // at or just past limit
        else if (shape < 3) len = $urandom_range(lim + 2, 1);
        else len = $urandom_range((lim < 6) ? lim : 6, 1);       // short, the common case
        cut = ($urandom_range(99) < 8);
        for (int k = 0; k < len; k++)
          send_beat(pmf_pkg::OP_PUSH, BW'($urandom), !cut && k == len - 1);
      end else begin
        send_beat(pmf_pkg::OP_POP, BW'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    hold_off        <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= pmf_pkg::OP_PUSH;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    beats_sent    = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cur_max_len   = 32;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-size limit, no idling. Empty pop, byte extremes, pop mid-push.
    start_phase(6'd32, 0, 0);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b0);      // empty queue
    send_beat(pmf_pkg::OP_PUSH, 8'h00, 1'b1);     // one-byte message
    send_beat(pmf_pkg::OP_PUSH, 8'hFF, 1'b0);
    send_beat(pmf_pkg::OP_PUSH, 8'h80, 1'b1);
    send_beat(pmf_pkg::OP_POP, 8'hFF, 1'b1);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b0);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b0);      // empty again
    send_beat(pmf_pkg::OP_PUSH, 8'h5A, 1'b1);
    send_beat(pmf_pkg::OP_PUSH, 8'h01, 1'b0);
    send_beat(pmf_pkg::OP_PUSH, 8'h02, 1'b0);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b0);      // abandons the partial message
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b0);
    random_traffic(90, 55);

    // One-byte limit, busy sender gaps: fill the pool, hit full, then a
    // too-long message while full (error has priority).
    start_phase(6'd1, 75, 0);
    for (int i = 0; i < pmf_pkg::POOL_ENTRIES_DEF; i++)
      send_beat(pmf_pkg::OP_PUSH, BW'($urandom), 1'b1);
    send_beat(pmf_pkg::OP_PUSH, 8'hC3, 1'b1);
    send_beat(pmf_pkg::OP_PUSH, 8'h3C, 1'b0);
    send_beat(pmf_pkg::OP_PUSH, 8'h99, 1'b1);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b1);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b1);
    random_traffic(60, 55);

    // Zero limit: every push is too long. Receiver stalls heavily.
    start_phase(6'd0, 0, 75);
    send_beat(pmf_pkg::OP_PUSH, 8'hFF, 1'b1);
    send_beat(pmf_pkg::OP_PUSH, 8'h00, 1'b0);
    send_beat(pmf_pkg::OP_PUSH, 8'hAA, 1'b1);
    send_beat(pmf_pkg::OP_POP, 8'h00, 1'b0);
    random_traffic(40, 45);

    // Register at its 6-bit maximum, clamped by the node size. Both sides idle.
    // Ends with a partial message that runs across the next register write.
    start_phase(6'd63, 35, 35);
    random_traffic(90, 50);
    for (int i = 0; i < 5; i++)
      send_beat(pmf_pkg::OP_PUSH, BW'($urandom), 1'b0);

    // Limit drops to 8 mid-message: the remaining bytes push it past the limit.
    // Then the receiver holds off for a long stretch while pushes keep coming,
    // so the output backs up and the input stalls.
    start_phase(6'd8, 0, 0);
    for (int i = 0; i < 5; i++)
      send_beat(pmf_pkg::OP_PUSH, BW'($urandom), i == 4);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    random_traffic(80, 75);

    // Mid-range limit with both sides slow.
    start_phase(6'd20, 75, 75);
    random_traffic(70, 50);

    drain();
    if (fail_count == 0 && awaited == 0) begin
      $display("pooled_message_fifo: match");
    end else begin
      $display("pooled_message_fifo: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("pooled_message_fifo: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/pmf_pkg.sv
sv/pmf_in_if.sv
sv/pmf_out_if.sv
sv/pooled_message_fifo.sv
sim/pmf_result_checker.sv
sim/tb_top.sv
